### rtl/core/ccs_pkg.sv
// Shared types and constants for the comment stripper.
package ccs_pkg;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChStar      = 8'h2A;

  // Result queue depth; needs room for the two results one byte can cause.
  localparam int unsigned ResultDepthDefault = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       stream_end;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic line_comment_active;
    logic block_comment_active;
    logic string_active;
    logic escape_pending;
    logic slash_held;
    logic star_held;
  } scan_state_t;

endpackage

### rtl/core/ccs_scan.sv
// Next-state and result logic for one input byte of the comment stripper.
module ccs_scan (
  input  ccs_pkg::scan_state_t state_i,
  input  logic                 strings_enable_i,
  input  ccs_pkg::in_item_t    item_i,
  output ccs_pkg::scan_state_t state_o,
  output logic [1:0]           num_o,
  output ccs_pkg::out_item_t   res0_o,
  output ccs_pkg::out_item_t   res1_o
);
  import ccs_pkg::*;

  logic        [7:0] c;
  logic              last;
  logic              taken;
  logic              slash_prev;
  logic              emit_c;
  logic              slash_end;
  logic        [1:0] cnt;
  scan_state_t       st;

  always_comb begin
    c          = item_i.in_byte;
    last       = item_i.in_last;
    st         = state_i;
    taken      = 1'b0;
    slash_prev = 1'b0;
    emit_c     = 1'b0;
    slash_end  = 1'b0;

    // Resolve the slash held from the previous byte.
    if (state_i.slash_held) begin
      st.slash_held = 1'b0;
      if (c == ChSlash) begin
        st.line_comment_active = 1'b1;
        taken = 1'b1;
      end else if (c == ChStar) begin
        st.block_comment_active = 1'b1;
        st.star_held = 1'b0;
        taken = 1'b1;
      end else begin
        slash_prev = 1'b1;
      end
    end

    if (!taken) begin
      if (strings_enable_i && c == ChQuote && !st.line_comment_active &&
          !st.block_comment_active && !st.string_active) begin
        st.string_active  = 1'b1;
        st.escape_pending = 1'b0;
        emit_c = 1'b1;
      end else if (strings_enable_i && st.string_active && c == ChQuote &&
                   !st.escape_pending) begin
        st.string_active = 1'b0;
        emit_c = 1'b1;
      end else if (strings_enable_i && st.string_active) begin
        st.escape_pending = (c == ChBackslash) ? !st.escape_pending : 1'b0;
        emit_c = 1'b1;
      end else if (st.line_comment_active) begin
        if (c == ChNewline) begin
          st.line_comment_active = 1'b0;
        end
      end else if (st.block_comment_active) begin
        if (st.star_held && c == ChSlash) begin
          st.block_comment_active = 1'b0;
          st.star_held = 1'b0;
        end else begin
          st.star_held = (c == ChStar);
        end
      end else if (!st.string_active && c == ChSlash) begin
        st.slash_held = 1'b1;
      end else begin
        emit_c = 1'b1;
      end
    end

    // A slash still waiting at end of stream is an ordinary byte.
    if (last && st.slash_held) begin
      slash_end = 1'b1;
    end

    cnt = 2'({1'b0, slash_prev} + {1'b0, emit_c} + {1'b0, slash_end});

    res0_o = '0;
    res1_o = '0;
    res0_o.has_byte = 1'b1;
    res1_o.has_byte = 1'b1;
    res0_o.out_byte = slash_prev ? ChSlash : (emit_c ? c : ChSlash);
    res1_o.out_byte = emit_c ? c : ChSlash;

    if (last && cnt == 2'd0) begin
      // empty end marker
      res0_o.has_byte = 1'b0;
      res0_o.out_byte = '0;
      cnt = 2'd1;
    end

    if (cnt == 2'd2) begin
      res1_o.run_last   = 1'b1;
      res1_o.stream_end = last;
    end else begin
      res0_o.run_last   = 1'b1;
      res0_o.stream_end = last;
    end

    num_o = cnt;
    state_o = last ? '0 : st;
  end

endmodule

### rtl/core/ccs_result_fifo.sv
// Small result queue: takes up to two results per cycle, hands out one.
module ccs_result_fifo #(
  parameter int unsigned Depth = ccs_pkg::ResultDepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [1:0]                          push_num_i,
  input  ccs_pkg::out_item_t                  push0_i,
  input  ccs_pkg::out_item_t                  push1_i,
  input  logic                                pop_i,
  output ccs_pkg::out_item_t                  head_o,
  output logic                                not_empty_o,
  output logic                                room2_o,
  output logic [$clog2(Depth+1)-1:0]          cnt_o
);
  import ccs_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  out_item_t        mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d, wr1;
  logic [CntW-1:0]  cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr1 = ptr_inc(wr_q);

  always_comb begin
    unique case (push_num_i)
      2'd0:    wr_d = wr_q;
      2'd1:    wr_d = wr1;
      default: wr_d = ptr_inc(wr1);
    endcase
    rd_d  = pop_i ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_num_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_num_i == 2'd2) begin
      mem_q[wr1] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign head_o      = mem_q[rd_q];
  assign not_empty_o = (cnt_q != '0);
  assign room2_o     = (cnt_q <= CntW'(Depth - 2));
  assign cnt_o       = cnt_q;

endmodule

### rtl/core/c_comment_stripper.sv
// Top level of the C/C++ comment stripper.
// Takes one source byte per cycle and passes on the bytes outside comments
// (and, with strings_enable set, keeps double-quoted strings intact). A byte
// is taken at every edge where in_valid_i is high and in_stall_o low; its
// results go into the result queue behind any earlier ones. Most bytes
// cause zero or one result, so with out_stall_i low the sustained rate is
// one byte per cycle; a held slash that does not open a comment gives two
// results. Results wait in a ResultDepth-entry queue, and in_stall_o rises
// while fewer than two entries are free. The last byte of a stream
// (in_last) always causes at least one result, marked stream_end, and
// returns the scanner state to idle. strings_enable is written through the
// cfg port, which is always ready; write it only while the block is idle.
module c_comment_stripper #(
  parameter int unsigned ResultDepth = ccs_pkg::ResultDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ccs_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ccs_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);
  import ccs_pkg::*;

  scan_state_t               state_q, state_d;
  logic                      strings_enable_q;
  logic [1:0]                scan_num, push_num;
  out_item_t                 res0, res1;
  logic                      in_acc, out_acc, room2;
  logic [$clog2(ResultDepth+1)-1:0] fifo_cnt;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = ~room2;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_acc     = out_valid_o & ~out_stall_i;
  assign push_num    = in_acc ? scan_num : 2'd0;

  ccs_scan u_scan (
    .state_i          (state_q),
    .strings_enable_i (strings_enable_q),
    .item_i           (in_data_i),
    .state_o          (state_d),
    .num_o            (scan_num),
    .res0_o           (res0),
    .res1_o           (res1)
  );

  ccs_result_fifo #(
    .Depth (ResultDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_num_i  (push_num),
    .push0_i     (res0),
    .push1_i     (res1),
    .pop_i       (out_acc),
    .head_o      (out_data_o),
    .not_empty_o (out_valid_o),
    .room2_o     (room2),
    .cnt_o       (fifo_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= '0;
      strings_enable_q <= 1'b1;
    end else begin
      if (in_acc) begin
        state_q <= state_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        strings_enable_q <= cfg_data_i;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt <= ($clog2(ResultDepth+1))'(ResultDepth))
    else $error("result queue overflow");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.in_last |=> state_q == '0)
    else $error("scanner state not idle after stream end");

  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.stream_end |-> out_data_o.run_last)
    else $error("stream end transaction without run_last");

  a_marker_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_byte |->
      out_data_o.stream_end && out_data_o.out_byte == 8'h00)
    else $error("malformed empty end marker");
`endif

endmodule
